@@ rtl/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the 8-bit HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  // hue sectors, one per sixth of the color circle
  typedef enum logic [2:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } sector_e;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  localparam int unsigned FracW = 16;   // 0..65025 scaled fraction
  localparam int unsigned NumW  = 24;   // value * fraction
  localparam logic [FracW-1:0] FullSq = 16'd65025;

  // output scale 255999/255000 reduced to 85333/85000, folded with 1/65025
  localparam int unsigned ScaleW   = 17;
  localparam logic [ScaleW-1:0] ScaleNum = 17'd85333;
  localparam int unsigned DivW     = 33;
  localparam logic [DivW-1:0] DivD = 33'd5527125000;   // 65025 * 85000

  // reciprocal estimate of ScaleNum / DivD, never above the exact quotient
  localparam int unsigned RecipShift = 40;
  localparam int unsigned RecipW     = 25;
  localparam logic [63:0] RecipFull  =
      (64'd1 << RecipShift) * 64'(ScaleNum) / 64'(DivD);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipFull);

  localparam int unsigned ProdW = NumW + RecipW;      // estimate product
  localparam int unsigned CmpW  = 41;                 // exact compare width

endpackage

`default_nettype wire

@@ rtl/hsv_to_rgb_8bit_core.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_8bit_core
// Pipelined 8-bit HSV to RGB color converter, one pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   input channel : in_valid_i / in_stall_o with hue, saturation and value.
//   output channel: out_valid_o / out_stall_i with red, green and blue.
//   A transaction moves on a rising edge with valid high and stall low.
//   The accepting edge loads the first stage, and the transaction passes
//   through every stage in order up to out_valid_o. A new transaction can
//   enter every cycle while the output is not stalled, so throughput is one per clock.
//   Six register stages: sector split, fraction forming, value multiply,
//   reciprocal estimate, exact compare operands, and the output register.
//   When the receiver stalls, the result holds in the output register and
//   earlier stages keep filling until every stage holds a transaction; only
//   then is in_stall_o raised. Bubbles are squeezed out on the way.
//   Reset clears all stage valid bits; data registers are not reset.
//   The block keeps no state between transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_8bit_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [hsv2rgb_pkg::ChanW-1:0] hue_in_i,
  input  wire logic [hsv2rgb_pkg::ChanW-1:0] saturation_in_i,
  input  wire logic [hsv2rgb_pkg::ChanW-1:0] value_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [hsv2rgb_pkg::ChanW-1:0]   red_out_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]   green_out_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]   blue_out_o
);

  import hsv2rgb_pkg::*;

  localparam int unsigned NumStg = 6;

  // ---------------------------------------------------------------- control
  logic [NumStg-1:0] vld_q;
  logic [NumStg:0]   en;   // en[k]: stage k loads; en[NumStg]: output taken

  always_comb begin
    en[NumStg] = !out_stall_i;
    for (int k = NumStg - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NumStg-1];

  // ------------------------------------------------ stage 0: sector split
  // h6 = 6*hue, sector = floor(h6/255) by compares, rem = h6 - 255*sector
  logic [10:0]       h6;
  logic [10:0]       base;
  sector_e           sec_d;
  logic [ChanW-1:0]  rem_d;

  sector_e           sec0_q;
  logic [ChanW-1:0]  rem0_q;
  logic [ChanW-1:0]  sat0_q;
  logic [ChanW-1:0]  val0_q;

  always_comb begin
    h6 = (11'(hue_in_i) << 2) + (11'(hue_in_i) << 1);
    if (h6 >= 11'd1530) begin
      // hue at the top of the circle wraps to the start of red
      sec_d = SecRed;
      base  = h6;
    end else if (h6 >= 11'd1275) begin
      sec_d = SecMagenta;
      base  = 11'd1275;
    end else if (h6 >= 11'd1020) begin
      sec_d = SecBlue;
      base  = 11'd1020;
    end else if (h6 >= 11'd765) begin
      sec_d = SecCyan;
      base  = 11'd765;
    end else if (h6 >= 11'd510) begin
      sec_d = SecGreen;
      base  = 11'd510;
    end else if (h6 >= 11'd255) begin
      sec_d = SecYellow;
      base  = 11'd255;
    end else begin
      sec_d = SecRed;
      base  = 11'd0;
    end
    rem_d = ChanW'(h6 - base);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sec0_q <= sec_d;
      rem0_q <= rem_d;
      sat0_q <= saturation_in_i;
      val0_q <= value_in_i;
    end
  end

  // -------------------------------------------- stage 1: fractions p, q, t
  logic [FracW-1:0] s_rem;
  logic [FracW-1:0] s_inv;
  logic [FracW-1:0] xp;
  logic [FracW-1:0] xq;
  logic [FracW-1:0] xt;
  logic [FracW-1:0] x_d [NumChan];

  logic [FracW-1:0] x1_q [NumChan];
  logic [ChanW-1:0] val1_q;

  always_comb begin
    s_rem = 16'(sat0_q) * 16'(rem0_q);
    s_inv = 16'(sat0_q) * 16'(8'd255 - rem0_q);
    xp    = 16'(8'd255 - sat0_q) * 16'd255;
    xq    = FullSq - s_rem;
    xt    = FullSq - s_inv;
    case (sec0_q)
      SecRed: begin
        x_d[ChRed] = FullSq; x_d[ChGreen] = xt;     x_d[ChBlue] = xp;
      end
      SecYellow: begin
        x_d[ChRed] = xq;     x_d[ChGreen] = FullSq; x_d[ChBlue] = xp;
      end
      SecGreen: begin
        x_d[ChRed] = xp;     x_d[ChGreen] = FullSq; x_d[ChBlue] = xt;
      end
      SecCyan: begin
        x_d[ChRed] = xp;     x_d[ChGreen] = xq;     x_d[ChBlue] = FullSq;
      end
      SecBlue: begin
        x_d[ChRed] = xt;     x_d[ChGreen] = xp;     x_d[ChBlue] = FullSq;
      end
      default: begin
        x_d[ChRed] = FullSq; x_d[ChGreen] = xp;     x_d[ChBlue] = xq;
      end
    endcase
    // grey: full fraction on all channels; the scaled value is exactly value
    if (sat0_q == '0) begin
      for (int c = 0; c < NumChan; c++) begin
        x_d[c] = FullSq;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      x1_q   <= x_d;
      val1_q <= val0_q;
    end
  end

  // ------------------------------------------ stage 2: numerator v * frac
  logic [NumW-1:0] n2_q [NumChan];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int c = 0; c < NumChan; c++) begin
        n2_q[c] <= NumW'(val1_q) * NumW'(x1_q[c]);
      end
    end
  end

  // ------------------------------------- stage 3: reciprocal estimate
  // estimate is the exact quotient or one below it
  logic [ProdW-1:0] prod3 [NumChan];
  logic [ChanW-1:0] est3_q [NumChan];
  logic [NumW-1:0]  n3_q  [NumChan];

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      prod3[c] = ProdW'(n2_q[c]) * ProdW'(Recip);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int c = 0; c < NumChan; c++) begin
        est3_q[c] <= prod3[c][RecipShift +: ChanW];
        n3_q[c]   <= n2_q[c];
      end
    end
  end

  // ------------------------------------- stage 4: exact compare operands
  logic [CmpW-1:0]  num4_q [NumChan];
  logic [CmpW-1:0]  lim4_q [NumChan];
  logic [ChanW-1:0] est4_q [NumChan];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int c = 0; c < NumChan; c++) begin
        num4_q[c] <= CmpW'(n3_q[c]) * CmpW'(ScaleNum);
        lim4_q[c] <= (CmpW'(est3_q[c]) + CmpW'(1)) * CmpW'(DivD);
        est4_q[c] <= est3_q[c];
      end
    end
  end

  // -------------------------------------------- stage 5: output register
  logic [ChanW-1:0] out5_q [NumChan];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int c = 0; c < NumChan; c++) begin
        out5_q[c] <= est4_q[c] + ChanW'(num4_q[c] >= lim4_q[c]);
      end
    end
  end

  assign red_out_o   = out5_q[ChRed];
  assign green_out_o = out5_q[ChGreen];
  assign blue_out_o  = out5_q[ChBlue];

  // ------------------------------------------------------------ assertions
  // input is only held off when every stage holds a transaction
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled with a free pipeline stage");

  // sector remainder stays below one sector width
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (rem0_q != 8'd255))
    else $error("sector remainder out of range");

  // fractions never exceed one
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (x1_q[ChRed] <= FullSq && x1_q[ChGreen] <= FullSq
                  && x1_q[ChBlue] <= FullSq))
    else $error("fraction above full scale");

  // reciprocal estimate is off by at most one
  a_est_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> (num4_q[ChRed] < lim4_q[ChRed] + CmpW'(DivD)
                  && num4_q[ChGreen] < lim4_q[ChGreen] + CmpW'(DivD)
                  && num4_q[ChBlue] < lim4_q[ChBlue] + CmpW'(DivD)))
    else $error("quotient estimate more than one below");

  // a stalled result stays in place
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(red_out_o)
                                      && $stable(green_out_o)
                                      && $stable(blue_out_o)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
